>>> rtl/prle_pkg.sv
// ----------------------------------------------------------------------------
// prle_pkg
// Shared types, codes and constants of the palette RLE sprite line decoder.
// ----------------------------------------------------------------------------
package prle_pkg;

    // Request type codes of the input channel
    localparam logic [1:0] REQ_PAL  = 2'd0;
    localparam logic [1:0] REQ_LINE = 2'd1;
    localparam logic [1:0] REQ_DATA = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_CROP_WIDTH    = 3'd0;
    localparam logic [2:0] CFG_CANVAS_WIDTH  = 3'd1;
    localparam logic [2:0] CFG_CANVAS_HEIGHT = 3'd2;
    localparam logic [2:0] CFG_LEFT_MARGIN   = 3'd3;
    localparam logic [2:0] CFG_TOP_MARGIN    = 3'd4;

    localparam int DIM_W     = 12;
    localparam int MARGIN_W  = 13;
    localparam int LEN_W     = 9;
    localparam int IDX_W     = 8;
    localparam int RGB_W     = 24;
    localparam int CFG_IDX_W = 3;

    localparam logic [IDX_W-1:0] SEG_LITERAL = 8'hFF;
    localparam logic [7:0]       ALPHA_OPAQUE = 8'd255;

    // Parser phase
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_SEG  = 2'd1,
        PH_LEN  = 2'd2,
        PH_LIT  = 2'd3
    } phase_t;

    // Configuration set
    typedef struct packed {
        logic [DIM_W-1:0]           crop_width;
        logic [DIM_W-1:0]           canvas_width;
        logic [DIM_W-1:0]           canvas_height;
        logic signed [MARGIN_W-1:0] left_margin;
        logic signed [MARGIN_W-1:0] top_margin;
    } cfg_t;

    // One decoded run before clipping and color lookup
    typedef struct packed {
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
        logic [LEN_W-1:0] len;
        logic [IDX_W-1:0] idx;
        logic             line_end;
    } run_t;

    // Palette memory read request
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } pal_rd_t;

    // Alpha of the reserved transparent and shadow indices
    function automatic logic [7:0] low_alpha(input logic [2:0] idx);
        logic [7:0] a;
        begin
            case (idx)
                3'd0, 3'd1:       a = 8'd0;
                3'd2:             a = 8'd64;
                3'd3, 3'd4, 3'd5: a = 8'd128;
                3'd6:             a = 8'd160;
                default:          a = 8'd192;
            endcase
            return a;
        end
    endfunction

endpackage

>>> rtl/prle_palette_ram.sv
// ----------------------------------------------------------------------------
// prle_palette_ram
// 256 x 24 palette memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module prle_palette_ram (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [prle_pkg::IDX_W-1:0] wr_addr,
    input  logic [prle_pkg::RGB_W-1:0] wr_data,
    input  prle_pkg::pal_rd_t          rd,
    output logic [prle_pkg::RGB_W-1:0] rd_data
);
    import prle_pkg::*;

    logic [RGB_W-1:0] mem [0:(1 << IDX_W)-1];
    logic [RGB_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/prle_line_parser.sv
// ----------------------------------------------------------------------------
// prle_line_parser
// Line state machine: parses segment, length and literal bytes into runs and
// holds each run in a stage register while its palette entry is read.
// ----------------------------------------------------------------------------
module prle_line_parser (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       accept,
    input  logic [1:0]                 req_type,
    input  logic [prle_pkg::DIM_W-1:0] line_row,
    input  logic [prle_pkg::IDX_W-1:0] data_byte,
    input  logic [prle_pkg::DIM_W-1:0] crop_width,
    input  logic                       run_take,
    output logic                       run_valid,
    output prle_pkg::run_t             run,
    output prle_pkg::pal_rd_t          pal_rd
);
    import prle_pkg::*;

    phase_t           phase_reg, phase_next;
    logic [DIM_W-1:0] col_reg, col_next;
    logic [DIM_W-1:0] row_reg, row_next;
    logic [IDX_W-1:0] seg_reg, seg_next;
    logic [LEN_W-1:0] lit_reg, lit_next;
    logic             run_valid_reg, run_valid_next;
    run_t             run_reg, run_next;

    logic             emit;
    logic [DIM_W-1:0] room;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] fill_n;
    logic [DIM_W:0]   fill_sum;
    logic             fill_end;
    logic [DIM_W:0]   lit_sum;
    logic             lit_end;

    // Fill run length cut at the crop width
    always_comb begin
        room     = (crop_width > col_reg) ? (crop_width - col_reg) : '0;
        len      = {1'b0, data_byte} + LEN_W'(1);
        fill_n   = ({{(DIM_W-LEN_W){1'b0}}, len} < room) ? len : room[LEN_W-1:0];
        fill_sum = {1'b0, col_reg} + {{(DIM_W+1-LEN_W){1'b0}}, fill_n};
        fill_end = fill_sum >= {1'b0, crop_width};
        lit_sum  = {1'b0, col_reg} + (DIM_W+1)'(1);
        lit_end  = lit_sum >= {1'b0, crop_width};
    end

    // Next parse state and run
    always_comb begin
        phase_next  = phase_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        seg_next    = seg_reg;
        lit_next    = lit_reg;
        emit        = 1'b0;
        run_next    = run_reg;
        pal_rd.en   = 1'b0;
        pal_rd.addr = data_byte;

        if (accept) begin
            unique case (req_type)
                REQ_LINE: begin
                    row_next   = line_row;
                    col_next   = '0;
                    seg_next   = '0;
                    lit_next   = '0;
                    phase_next = (crop_width == '0) ? PH_IDLE : PH_SEG;
                end
                REQ_DATA: begin
                    unique case (phase_reg)
                        PH_SEG: begin
                            seg_next   = data_byte;
                            phase_next = PH_LEN;
                        end
                        PH_LEN: begin
                            if (seg_reg == SEG_LITERAL) begin
                                lit_next   = len;
                                phase_next = PH_LIT;
                            end else begin
                                emit              = 1'b1;
                                pal_rd.en         = 1'b1;
                                pal_rd.addr       = seg_reg;
                                run_next.row      = row_reg;
                                run_next.col      = col_reg;
                                run_next.len      = fill_n;
                                run_next.idx      = seg_reg;
                                run_next.line_end = fill_end;
                                col_next          = fill_sum[DIM_W-1:0];
                                phase_next        = fill_end ? PH_IDLE : PH_SEG;
                            end
                        end
                        PH_LIT: begin
                            emit              = 1'b1;
                            pal_rd.en         = 1'b1;
                            run_next.row      = row_reg;
                            run_next.col      = col_reg;
                            run_next.len      = LEN_W'(1);
                            run_next.idx      = data_byte;
                            run_next.line_end = lit_end;
                            col_next          = lit_sum[DIM_W-1:0];
                            if (lit_reg != '0) begin
                                lit_next = lit_reg - LEN_W'(1);
                            end
                            if (lit_end) begin
                                phase_next = PH_IDLE;
                            end else if (lit_next == '0) begin
                                phase_next = PH_SEG;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    // Stage register occupancy
    always_comb begin
        run_valid_next = run_valid_reg;
        if (accept) begin
            run_valid_next = emit;
        end else if (run_take) begin
            run_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            seg_reg       <= '0;
            lit_reg       <= '0;
            run_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            seg_reg       <= seg_next;
            lit_reg       <= lit_next;
            run_valid_reg <= run_valid_next;
        end
    end

    // Run payload
    always_ff @(posedge aclk) begin
        run_reg <= run_next;
    end

    assign run_valid = run_valid_reg;
    assign run       = run_reg;

endmodule

>>> rtl/prle_run_emit.sv
// ----------------------------------------------------------------------------
// prle_run_emit
// Clips a run to the canvas, resolves its color and holds it in the output
// register until the receiver takes it.
// ----------------------------------------------------------------------------
module prle_run_emit (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  prle_pkg::cfg_t             cfg,
    input  logic                       run_valid,
    input  prle_pkg::run_t             run,
    input  logic [prle_pkg::RGB_W-1:0] pal_rgb,
    output logic                       run_take,
    input  logic                       m_ready,
    output logic                       m_valid,
    output logic [prle_pkg::DIM_W-1:0] m_dest_x,
    output logic [prle_pkg::DIM_W-1:0] m_dest_y,
    output logic [prle_pkg::LEN_W-1:0] m_run_length,
    output logic [7:0]                 m_red,
    output logic [7:0]                 m_green,
    output logic [7:0]                 m_blue,
    output logic [7:0]                 m_alpha,
    output logic                       m_line_end
);
    import prle_pkg::*;

    logic                  m_valid_reg, m_valid_next;
    logic [DIM_W-1:0]      dest_x_reg, dest_y_reg;
    logic [LEN_W-1:0]      len_reg;
    logic [7:0]            red_reg, green_reg, blue_reg, alpha_reg;
    logic                  line_end_reg;

    logic signed [DIM_W+1:0] dy;
    logic signed [DIM_W+1:0] x0;
    logic signed [DIM_W+2:0] x1, lo, hi, cw_s, span;
    logic                    vis_y;
    logic                    vis;
    logic [DIM_W-1:0]        vx, vy;
    logic [LEN_W-1:0]        vlen;
    logic                    low_idx;
    logic [7:0]              r, g, b, a;

    assign run_take = run_valid && (!m_valid_reg || m_ready);

    // Clip the run to the canvas
    always_comb begin
        dy    = {cfg.top_margin[MARGIN_W-1], cfg.top_margin} + $signed({2'b00, run.row});
        x0    = {cfg.left_margin[MARGIN_W-1], cfg.left_margin} + $signed({2'b00, run.col});
        x1    = {x0[DIM_W+1], x0} + $signed({{(DIM_W+3-LEN_W){1'b0}}, run.len});
        cw_s  = $signed({3'b000, cfg.canvas_width});
        lo    = x0[DIM_W+1] ? '0 : {1'b0, x0};
        hi    = (x1 > cw_s) ? cw_s : x1;
        span  = hi - lo;
        vis_y = !dy[DIM_W+1] && (dy[DIM_W:0] < {1'b0, cfg.canvas_height});
        vis   = vis_y && (hi > lo);
        vx    = vis ? lo[DIM_W-1:0] : '0;
        vy    = vis ? dy[DIM_W-1:0] : '0;
        vlen  = vis ? span[LEN_W-1:0] : '0;
    end

    // Resolve the run color
    always_comb begin
        low_idx = (run.idx[IDX_W-1:3] == '0);
        if (low_idx) begin
            r = '0;
            g = '0;
            b = '0;
            a = low_alpha(run.idx[2:0]);
        end else begin
            r = pal_rgb[23:16];
            g = pal_rgb[15:8];
            b = pal_rgb[7:0];
            a = ALPHA_OPAQUE;
        end
    end

    // Output register occupancy
    always_comb begin
        m_valid_next = m_valid_reg;
        if (run_take) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Load the result on transfer from the stage register
    always_ff @(posedge aclk) begin
        if (run_take) begin
            dest_x_reg   <= vx;
            dest_y_reg   <= vy;
            len_reg      <= vlen;
            red_reg      <= r;
            green_reg    <= g;
            blue_reg     <= b;
            alpha_reg    <= a;
            line_end_reg <= run.line_end;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_dest_x     = dest_x_reg;
    assign m_dest_y     = dest_y_reg;
    assign m_run_length = len_reg;
    assign m_red        = red_reg;
    assign m_green      = green_reg;
    assign m_blue       = blue_reg;
    assign m_alpha      = alpha_reg;
    assign m_line_end   = line_end_reg;

endmodule

>>> rtl/palette_rle_sprite_line_decoder_core.sv
// ----------------------------------------------------------------------------
// palette_rle_sprite_line_decoder_core
// Decodes run-length coded sprite lines of palette indices into clipped
// RGBA runs.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel carries one request per transfer: a palette write, a line
//   start at a source row, or one coded byte of the current line.
//   m_* channel returns one clipped RGBA run for each fill run length byte
//   and for each literal byte; all other requests return nothing.
//   cfg_* channel writes crop width, canvas size and margins by index, always
//   ready. Write it only while idle; the decoder itself does not enforce it.
// Pipeline and throughput:
//   A run passes from the coded byte transfer into the parser stage register,
//   where the palette memory is read, then into the output register on m_*.
//   One request is taken every cycle while s_ready is high; the palette memory
//   has one write and one read port, so a palette write and a lookup never
//   collide.
// Reset:
//   Parser goes idle at column 0, row 0; control registers take their reset values.
//   The palette is not cleared and holds garbage until written.
// Stall:
//   With m_ready low the output register holds its run, the parser stage
//   fills behind it, and s_ready drops only once both are occupied.
// ----------------------------------------------------------------------------
module palette_rle_sprite_line_decoder_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Request channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_req_type,
    input  logic [prle_pkg::IDX_W-1:0]     s_pal_index,
    input  logic [prle_pkg::RGB_W-1:0]     s_pal_rgb,
    input  logic [prle_pkg::DIM_W-1:0]     s_line_row,
    input  logic [prle_pkg::IDX_W-1:0]     s_data_byte,
    // Result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [prle_pkg::DIM_W-1:0]     m_dest_x,
    output logic [prle_pkg::DIM_W-1:0]     m_dest_y,
    output logic [prle_pkg::LEN_W-1:0]     m_run_length,
    output logic [7:0]                     m_red,
    output logic [7:0]                     m_green,
    output logic [7:0]                     m_blue,
    output logic [7:0]                     m_alpha,
    output logic                           m_line_end,
    // Configuration channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [prle_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [prle_pkg::MARGIN_W-1:0]  cfg_data
);
    import prle_pkg::*;

    cfg_t             cfg_reg, cfg_next;
    logic             accept;
    logic             run_valid;
    logic             run_take;
    run_t             run;
    pal_rd_t          pal_rd;
    logic [RGB_W-1:0] pal_rd_data;
    logic             pal_wr;

    assign cfg_ready = 1'b1;
    assign s_ready   = !run_valid || run_take;
    assign accept    = s_valid && s_ready;
    assign pal_wr    = accept && (s_req_type == REQ_PAL);

    // Decode configuration writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_addr)
                CFG_CROP_WIDTH:    cfg_next.crop_width    = cfg_data[DIM_W-1:0];
                CFG_CANVAS_WIDTH:  cfg_next.canvas_width  = cfg_data[DIM_W-1:0];
                CFG_CANVAS_HEIGHT: cfg_next.canvas_height = cfg_data[DIM_W-1:0];
                CFG_LEFT_MARGIN:   cfg_next.left_margin   = cfg_data;
                CFG_TOP_MARGIN:    cfg_next.top_margin    = cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.crop_width    <= DIM_W'(1);
            cfg_reg.canvas_width  <= DIM_W'(1);
            cfg_reg.canvas_height <= DIM_W'(1);
            cfg_reg.left_margin   <= '0;
            cfg_reg.top_margin    <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    prle_palette_ram u_palette (
        .aclk    (aclk),
        .wr_en   (pal_wr),
        .wr_addr (s_pal_index),
        .wr_data (s_pal_rgb),
        .rd      (pal_rd),
        .rd_data (pal_rd_data)
    );

    prle_line_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .req_type   (s_req_type),
        .line_row   (s_line_row),
        .data_byte  (s_data_byte),
        .crop_width (cfg_reg.crop_width),
        .run_take   (run_take),
        .run_valid  (run_valid),
        .run        (run),
        .pal_rd     (pal_rd)
    );

    prle_run_emit u_emit (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .run_valid    (run_valid),
        .run          (run),
        .pal_rgb      (pal_rd_data),
        .run_take     (run_take),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_dest_x     (m_dest_x),
        .m_dest_y     (m_dest_y),
        .m_run_length (m_run_length),
        .m_red        (m_red),
        .m_green      (m_green),
        .m_blue       (m_blue),
        .m_alpha      (m_alpha),
        .m_line_end   (m_line_end)
    );

endmodule
